// ----- src/elrdc_pkg.sv -----
// types, constants and helpers shared by the event log ring
`timescale 1ns / 1ps
package elrdc_pkg;

   localparam int RING_DEPTH  = 32;
   localparam int IDX_W       = $clog2(RING_DEPTH);
   localparam int CNT_W       = $clog2(RING_DEPTH + 1);
   localparam int SUM_W       = IDX_W + 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_W       = 32;
   localparam int CSR_IDX_W   = 2;

   localparam logic [4:0] DROP_EVENT = 5'd9;
   localparam logic [7:0] DROP_MAX   = 8'hFF;

   localparam logic [1:0] KIND_RECORD = 2'd0;
   localparam logic [1:0] KIND_TICK   = 2'd1;
   localparam logic [1:0] KIND_DRAIN  = 2'd2;
   localparam logic [1:0] KIND_DONE   = 2'd3;

   localparam logic [5:0]  RST_WATERMARK = 6'd16;
   localparam logic [31:0] RST_AGE_MS    = 32'd60000;
   localparam logic [31:0] RST_RETRY_MS  = 32'd30000;
   localparam logic [31:0] RST_POLL_MS   = 32'd500;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WATERMARK = 2'd0,
      CSR_AGE       = 2'd1,
      CSR_RETRY     = 2'd2,
      CSR_POLL      = 2'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      OP_RECORD = 2'd0,
      OP_TICK   = 2'd1,
      OP_DRAIN  = 2'd2,
      OP_DONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_STAMP = 2'd1,
      ST_ROW   = 2'd2
   } state_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [4:0]  event_code;
      logic [7:0]  aux_byte;
      logic [31:0] detail_word;
      logic [31:0] now_ms;
      logic [15:0] millivolts;
      logic [6:0]  percent;
      logic        charging;
      logic        ok;
   } req_type;

   typedef struct packed {
      logic        is_row;
      logic        flush_due;
      logic [4:0]  row_event;
      logic [7:0]  row_aux;
      logic [31:0] row_detail;
      logic [31:0] row_ms;
      logic [15:0] row_millivolts;
      logic [6:0]  row_percent;
      logic        row_charging;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [5:0]  fill_mark;
      logic [31:0] age_limit;
      logic [31:0] retry_hold;
      logic [31:0] poll_period;
   } cfg_type;

   typedef struct packed {
      op_type  op;
      req_type req;
   } item_type;

   typedef struct packed {
      logic [31:0] ms;
      logic [31:0] detail;
   } entry_td_type;

   typedef struct packed {
      logic [4:0]  event_code;
      logic [7:0]  aux;
      logic [15:0] millivolts;
      logic [6:0]  percent;
      logic        charging;
   } entry_info_type;

   typedef struct packed {
      logic [CNT_W-1:0] ring_count;
      logic             idle;
   } status_type;

   function automatic logic [IDX_W-1:0] inc_idx(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] res;
      if (idx == IDX_W'(RING_DEPTH - 1)) begin
         res = '0;
      end else begin
         res = idx + 1'b1;
      end
      return res;
   endfunction

endpackage

// ----- src/elrdc_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps
module elrdc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/elrdc_front.sv -----
// input side: accepts words, decodes the kind and queues them for the back end
`timescale 1ns / 1ps
module elrdc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  elrdc_pkg::req_type  req_data,
   output logic                q_valid,
   output elrdc_pkg::item_type q_item,
   input  logic                q_pop
);

   elrdc_pkg::item_type               slot_ff [elrdc_pkg::QUEUE_DEPTH];
   logic [elrdc_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [elrdc_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [elrdc_pkg::QCNT_W-1:0]      cnt_ff, cnt_in;
   elrdc_pkg::item_type               item;
   logic                              push;

   // decode
   always_comb begin
      item.req = req_data;
      case (req_data.kind)
         elrdc_pkg::KIND_RECORD: item.op = elrdc_pkg::OP_RECORD;
         elrdc_pkg::KIND_TICK:   item.op = elrdc_pkg::OP_TICK;
         elrdc_pkg::KIND_DRAIN:  item.op = elrdc_pkg::OP_DRAIN;
         elrdc_pkg::KIND_DONE:   item.op = elrdc_pkg::OP_DONE;
         default:                item.op = elrdc_pkg::OP_RECORD;
      endcase
   end

   assign req_stall = (cnt_ff == elrdc_pkg::QCNT_W'(elrdc_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != '0);
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         if (wr_ptr_ff == elrdc_pkg::QPTR_W'(elrdc_pkg::QUEUE_DEPTH - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + 1'b1;
         end
      end
      if (q_pop) begin
         if (rd_ptr_ff == elrdc_pkg::QPTR_W'(elrdc_pkg::QUEUE_DEPTH - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + 1'b1;
         end
      end
      if (push && !q_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && q_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// ----- src/elrdc_back.sv -----
// back end: ring storage, flush verdicts, drain sequencer and output register
`timescale 1ns / 1ps
module elrdc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  elrdc_pkg::cfg_type    cfg,
   input  logic                  q_valid,
   input  elrdc_pkg::item_type   q_item,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output elrdc_pkg::rsp_type    rsp_data,
   output elrdc_pkg::status_type status
);

   elrdc_pkg::state_type          state_ff, state_in;
   logic [elrdc_pkg::IDX_W-1:0]   head_ff, head_in;
   logic [elrdc_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [7:0]                    drop_ff, drop_in;
   logic [31:0]                   pending_ff, pending_in;
   logic [31:0]                   last_poll_ff, last_poll_in;
   logic                          failed_ff, failed_in;
   logic [31:0]                   fail_time_ff, fail_time_in;
   logic [elrdc_pkg::IDX_W-1:0]   ptr_ff, ptr_in;
   logic [elrdc_pkg::CNT_W-1:0]   row_idx_ff, row_idx_in;
   logic                          drop_phase_ff, drop_phase_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   elrdc_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic                          ram_we;
   logic [elrdc_pkg::IDX_W-1:0]   ram_waddr;
   elrdc_pkg::entry_td_type       td_wdata, td_rdata;
   elrdc_pkg::entry_info_type     info_wdata, info_rdata;

   logic                          out_free;
   logic                          ring_full;
   logic                          row_last;
   logic [elrdc_pkg::SUM_W-1:0]   slot_sum;
   logic [elrdc_pkg::IDX_W-1:0]   slot_idx;
   logic [31:0]                   poll_elapsed, age_elapsed, fail_elapsed;
   logic                          verdict;
   elrdc_pkg::req_type            req;

   assign req       = q_item.req;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign ring_full = (count_ff == elrdc_pkg::CNT_W'(elrdc_pkg::RING_DEPTH));
   assign row_last  = (row_idx_ff + 1'b1 == count_ff);

   // next free slot when not full
   assign slot_sum = elrdc_pkg::SUM_W'(head_ff) + elrdc_pkg::SUM_W'(count_ff);
   assign slot_idx = (slot_sum >= elrdc_pkg::SUM_W'(elrdc_pkg::RING_DEPTH))
                     ? elrdc_pkg::IDX_W'(slot_sum - elrdc_pkg::SUM_W'(elrdc_pkg::RING_DEPTH))
                     : elrdc_pkg::IDX_W'(slot_sum);

   // flush verdict
   assign poll_elapsed = req.now_ms - last_poll_ff;
   assign age_elapsed  = req.now_ms - pending_ff;
   assign fail_elapsed = req.now_ms - fail_time_ff;
   assign verdict = (poll_elapsed >= cfg.poll_period) && (count_ff != '0)
                    && ((32'(count_ff) >= 32'(cfg.fill_mark))
                        || (age_elapsed >= cfg.age_limit))
                    && (!failed_ff || (fail_elapsed >= cfg.retry_hold));

   assign q_pop = (state_ff == elrdc_pkg::ST_IDLE) && q_valid
                  && ((q_item.op != elrdc_pkg::OP_TICK) || out_free);

   elrdc_ram #(
      .WIDTH ($bits(elrdc_pkg::entry_td_type)),
      .DEPTH (elrdc_pkg::RING_DEPTH)
   ) u_td_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (td_wdata),
      .rd_addr (ptr_in),
      .rd_data (td_rdata)
   );

   elrdc_ram #(
      .WIDTH ($bits(elrdc_pkg::entry_info_type)),
      .DEPTH (elrdc_pkg::RING_DEPTH)
   ) u_info_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (info_wdata),
      .rd_addr (ptr_in),
      .rd_data (info_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         elrdc_pkg::ST_IDLE: begin
            if (q_valid && q_item.op == elrdc_pkg::OP_RECORD && ring_full) begin
               state_in = elrdc_pkg::ST_STAMP;
            end else if (q_valid && q_item.op == elrdc_pkg::OP_DRAIN && count_ff != '0) begin
               state_in = elrdc_pkg::ST_ROW;
            end
         end
         elrdc_pkg::ST_STAMP: begin
            state_in = elrdc_pkg::ST_IDLE;
         end
         elrdc_pkg::ST_ROW: begin
            if (out_free && !drop_phase_ff && row_last) begin
               state_in = elrdc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = elrdc_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      drop_in       = drop_ff;
      pending_in    = pending_ff;
      last_poll_in  = last_poll_ff;
      failed_in     = failed_ff;
      fail_time_in  = fail_time_ff;
      ptr_in        = ptr_ff;
      row_idx_in    = row_idx_ff;
      drop_phase_in = drop_phase_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;
      ram_waddr     = slot_idx;
      td_wdata.ms              = req.now_ms;
      td_wdata.detail          = req.detail_word;
      info_wdata.event_code    = req.event_code;
      info_wdata.aux           = req.aux_byte;
      info_wdata.millivolts    = req.millivolts;
      info_wdata.percent       = req.percent;
      info_wdata.charging      = req.charging;
      case (state_ff)
         elrdc_pkg::ST_IDLE: begin
            if (q_pop) begin
               case (q_item.op)
                  elrdc_pkg::OP_RECORD: begin
                     ram_we = 1'b1;
                     if (ring_full) begin
                        // overwrite oldest, fetch stamp of the new oldest
                        ram_waddr = head_ff;
                        head_in   = elrdc_pkg::inc_idx(head_ff);
                        ptr_in    = elrdc_pkg::inc_idx(head_ff);
                        if (drop_ff != elrdc_pkg::DROP_MAX) begin
                           drop_in = drop_ff + 1'b1;
                        end
                     end else begin
                        count_in = count_ff + 1'b1;
                        if (count_ff == '0) begin
                           pending_in = req.now_ms;
                        end
                     end
                  end
                  elrdc_pkg::OP_TICK: begin
                     if (poll_elapsed >= cfg.poll_period) begin
                        last_poll_in = req.now_ms;
                     end
                     rsp_valid_in        = 1'b1;
                     rsp_data_in         = '0;
                     rsp_data_in.flush_due = verdict;
                     rsp_data_in.last    = 1'b1;
                  end
                  elrdc_pkg::OP_DRAIN: begin
                     ptr_in        = head_ff;
                     row_idx_in    = '0;
                     drop_phase_in = (drop_ff != '0);
                  end
                  elrdc_pkg::OP_DONE: begin
                     if (req.ok) begin
                        head_in    = '0;
                        count_in   = '0;
                        drop_in    = '0;
                        pending_in = '0;
                        failed_in  = 1'b0;
                     end else begin
                        failed_in    = 1'b1;
                        fail_time_in = req.now_ms;
                     end
                  end
                  default: begin
                     ram_we = 1'b0;
                  end
               endcase
            end
         end
         elrdc_pkg::ST_STAMP: begin
            pending_in = td_rdata.ms;
         end
         elrdc_pkg::ST_ROW: begin
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.is_row         = 1'b1;
               rsp_data_in.flush_due      = 1'b0;
               rsp_data_in.row_ms         = td_rdata.ms;
               rsp_data_in.row_millivolts = info_rdata.millivolts;
               rsp_data_in.row_percent    = info_rdata.percent;
               rsp_data_in.row_charging   = info_rdata.charging;
               if (drop_phase_ff) begin
                  drop_phase_in          = 1'b0;
                  rsp_data_in.row_event  = elrdc_pkg::DROP_EVENT;
                  rsp_data_in.row_aux    = drop_ff;
                  rsp_data_in.row_detail = '0;
                  rsp_data_in.last       = 1'b0;
               end else begin
                  rsp_data_in.row_event  = info_rdata.event_code;
                  rsp_data_in.row_aux    = info_rdata.aux;
                  rsp_data_in.row_detail = td_rdata.detail;
                  rsp_data_in.last       = row_last;
                  if (!row_last) begin
                     ptr_in     = elrdc_pkg::inc_idx(ptr_ff);
                     row_idx_in = row_idx_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= elrdc_pkg::ST_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         drop_ff       <= '0;
         pending_ff    <= '0;
         last_poll_ff  <= '0;
         failed_ff     <= 1'b0;
         fail_time_ff  <= '0;
         ptr_ff        <= '0;
         row_idx_ff    <= '0;
         drop_phase_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         drop_ff       <= drop_in;
         pending_ff    <= pending_in;
         last_poll_ff  <= last_poll_in;
         failed_ff     <= failed_in;
         fail_time_ff  <= fail_time_in;
         ptr_ff        <= ptr_in;
         row_idx_ff    <= row_idx_in;
         drop_phase_ff <= drop_phase_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data          = rsp_data_ff;
   assign status.ring_count = count_ff;
   assign status.idle       = (state_ff == elrdc_pkg::ST_IDLE);

endmodule

// ----- src/event_log_ring_with_drop_count_core.sv -----
// top level of the event log ring with drop counter
`timescale 1ns / 1ps
//  channel   ports                            direction   word
//  req       req_valid req_stall req_data     in          one event, tick, drain or outcome
//  rsp       rsp_valid rsp_stall rsp_data     out         one verdict or log row
//  csr       csr_write_en csr_index csr_wdata in          register write, no read-back
//
// record, tick and outcome words are handled in the idle state of the back end; a record
// into a full ring also passes the stamp state, for the ram read of the new oldest stamp.
// a drain gives one row per cycle out of the entry rams while the output is not stalled.
// a two-word queue parts input from back end; the output register parts back end
// from the result side, so a stalled result holds the back end but not the queue.
// reset is synchronous; entry rams are not cleared and are read only where written.
module event_log_ring_with_drop_count_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  elrdc_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output elrdc_pkg::rsp_type                  rsp_data,
   input  logic                                csr_write_en,
   input  logic [elrdc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [elrdc_pkg::CSR_W-1:0]         csr_wdata
);

   elrdc_pkg::cfg_type    cfg_ff, cfg_in;
   logic                  q_valid;
   elrdc_pkg::item_type   q_item;
   logic                  q_pop;
   elrdc_pkg::status_type status;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            elrdc_pkg::CSR_WATERMARK: cfg_in.fill_mark   = csr_wdata[5:0];
            elrdc_pkg::CSR_AGE:       cfg_in.age_limit   = csr_wdata;
            elrdc_pkg::CSR_RETRY:     cfg_in.retry_hold  = csr_wdata;
            elrdc_pkg::CSR_POLL:      cfg_in.poll_period = csr_wdata;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fill_mark   <= elrdc_pkg::RST_WATERMARK;
         cfg_ff.age_limit   <= elrdc_pkg::RST_AGE_MS;
         cfg_ff.retry_hold  <= elrdc_pkg::RST_RETRY_MS;
         cfg_ff.poll_period <= elrdc_pkg::RST_POLL_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   elrdc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   elrdc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .status    (status)
   );

   // fill never above depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      status.ring_count <= elrdc_pkg::CNT_W'(elrdc_pkg::RING_DEPTH))
      else $error("ring fill above depth");

   // a verdict is a single closing word with no row fields
   a_verdict_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_row |-> rsp_data.last && rsp_data.row_detail == '0
         && rsp_data.row_ms == '0)
      else $error("malformed verdict");

   // rows never flag a flush
   a_row_no_due: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_row |-> !rsp_data.flush_due)
      else $error("row carries flush flag");

   // nothing leaves the queue while a drain or stamp fetch is running
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> status.idle && q_valid)
      else $error("queue popped outside idle");

endmodule

// ----- tb/sv/tb_event_log_ring_with_drop_count_core.sv -----
// testbench for the event log ring core: directed, register, drop, backpressure and random traffic
`timescale 1ns / 1ps
module tb_event_log_ring_with_drop_count_core;
   import elrdc_pkg::*;

   localparam int STALL_LIMIT = 4000;

   logic                 clock        = 1'b0;
   logic                 reset        = 1'b1;
   logic                 req_valid    = 1'b0;
   logic                 req_stall;
   req_type              req_data     = '0;
   logic                 rsp_valid;
   logic                 rsp_stall    = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index    = CSR_WATERMARK;
   logic [CSR_W-1:0]     csr_wdata    = '0;

   // shadow of the ring
   logic [31:0]    ring_ms     [RING_DEPTH];
   logic [31:0]    ring_detail [RING_DEPTH];
   entry_info_type ring_info   [RING_DEPTH];
   int             ring_first   = 0;
   int             ring_fill    = 0;
   logic [7:0]     lost_count   = '0;
   logic [31:0]    oldest_ms    = '0;
   logic [31:0]    poll_ms_mark = '0;
   logic [31:0]    fail_ms      = '0;
   logic           fail_flag    = 1'b0;
   cfg_type        ring_cfg     = {RST_WATERMARK, RST_AGE_MS, RST_RETRY_MS, RST_POLL_MS};

   rsp_type     awaited_words[$];
   logic [31:0] now_track        = '0;
   int          step_cap         = 300;
   bit          steady           = 1'b0;
   int          hold_cycles      = 0;
   int          error_count      = 0;
   int          words_in         = 0;
   int          rows_out         = 0;
   int          verdicts_out     = 0;
   int          due_out          = 0;
   int          peak_lost        = 0;
   int          settings_applied = 0;

   event_log_ring_with_drop_count_core dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic rsp_type ring_row(input int slot, input bit drop, input bit fin);
      rsp_type r;
      r                = '0;
      r.is_row         = 1'b1;
      r.row_event      = drop ? DROP_EVENT : ring_info[slot].event_code;
      r.row_aux        = drop ? lost_count : ring_info[slot].aux;
      r.row_detail     = drop ? 32'd0 : ring_detail[slot];
      r.row_ms         = ring_ms[slot];
      r.row_millivolts = ring_info[slot].millivolts;
      r.row_percent    = ring_info[slot].percent;
      r.row_charging   = ring_info[slot].charging;
      r.last           = fin;
      return r;
   endfunction

   task automatic advance_ring(input req_type w);
      int          slot;
      int          i;
      logic [31:0] since_poll;
      logic [31:0] age;
      logic [31:0] since_fail;
      rsp_type     verdict;
      since_poll = w.now_ms - poll_ms_mark;
      age        = w.now_ms - oldest_ms;
      since_fail = w.now_ms - fail_ms;
      case (w.kind)
         KIND_RECORD: begin
            if (ring_fill >= RING_DEPTH) begin
               ring_first = (ring_first + 1) % RING_DEPTH;
               ring_fill  = RING_DEPTH - 1;
               if (lost_count != DROP_MAX) lost_count++;
               oldest_ms = ring_ms[ring_first];
            end
            slot                        = (ring_first + ring_fill) % RING_DEPTH;
            ring_ms[slot]               = w.now_ms;
            ring_detail[slot]           = w.detail_word;
            ring_info[slot].event_code  = w.event_code;
            ring_info[slot].aux         = w.aux_byte;
            ring_info[slot].millivolts  = w.millivolts;
            ring_info[slot].percent     = w.percent;
            ring_info[slot].charging    = w.charging;
            if (ring_fill == 0) oldest_ms = w.now_ms;
            ring_fill++;
            if (int'(lost_count) > peak_lost) peak_lost = int'(lost_count);
         end
         KIND_TICK: begin
            verdict      = '0;
            verdict.last = 1'b1;
            if (since_poll >= ring_cfg.poll_period) begin
               poll_ms_mark = w.now_ms;
               if (ring_fill > 0
                   && (ring_fill >= int'(ring_cfg.fill_mark)
                       || age >= ring_cfg.age_limit)
                   && (!fail_flag || since_fail >= ring_cfg.retry_hold))
                  verdict.flush_due = 1'b1;
            end
            awaited_words.push_back(verdict);
         end
         KIND_DRAIN: begin
            if (ring_fill > 0) begin
               if (lost_count != 0) awaited_words.push_back(ring_row(ring_first, 1'b1, 1'b0));
               for (i = 0; i < ring_fill; i++)
                  awaited_words.push_back(ring_row((ring_first + i) % RING_DEPTH, 1'b0,
                                                   i == ring_fill - 1));
            end
         end
         KIND_DONE: begin
            if (w.ok) begin
               ring_first = 0;
               ring_fill  = 0;
               lost_count = '0;
               oldest_ms  = '0;
               fail_flag  = 1'b0;
            end else begin
               fail_flag = 1'b1;
               fail_ms   = w.now_ms;
            end
         end
         default: begin
         end
      endcase
   endtask

   function automatic req_type noise_word();
      req_type w;
      w.kind        = 2'($urandom_range(0, 3));
      w.event_code  = 5'($urandom_range(0, 31));
      w.aux_byte    = 8'($urandom);
      w.detail_word = $urandom;
      w.now_ms      = $urandom;
      w.millivolts  = 16'($urandom);
      w.percent     = 7'($urandom_range(0, 100));
      w.charging    = 1'($urandom);
      w.ok          = 1'($urandom);
      return w;
   endfunction

   function automatic req_type make_word(input logic [1:0] kind, input logic [31:0] stamp);
      req_type w;
      w        = noise_word();
      w.kind   = kind;
      w.now_ms = stamp;
      now_track = stamp;
      return w;
   endfunction

   function automatic logic [31:0] later_ms();
      if ($urandom_range(0, 29) == 0) now_track += $urandom_range(0, 200000);
      else now_track += $urandom_range(0, step_cap);
      return now_track;
   endfunction

   task automatic send_word(input req_type w);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  = w;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      advance_ring(w);
      words_in++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (awaited_words.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [31:0] value);
      csr_write_en = 1'b1;
      csr_index    = idx;
      csr_wdata    = value;
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic apply_settings(input cfg_type c);
      // upper bits of the watermark word are don't care
      write_reg(CSR_WATERMARK, {26'($urandom), c.fill_mark});
      write_reg(CSR_AGE, c.age_limit);
      write_reg(CSR_RETRY, c.retry_hold);
      write_reg(CSR_POLL, c.poll_period);
      ring_cfg = c;
      settings_applied++;
   endtask

   task automatic run_mix(input int count);
      int      r;
      int      burst;
      req_type w;
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            burst = $urandom_range(8, 40);
            repeat (burst) send_word(make_word(KIND_RECORD, later_ms()));
         end else if (r < 45) begin
            send_word(make_word(KIND_RECORD, later_ms()));
         end else if (r < 70) begin
            send_word(make_word(KIND_TICK, later_ms()));
         end else if (r < 82) begin
            send_word(make_word(KIND_DRAIN, later_ms()));
         end else if (r < 94) begin
            w    = make_word(KIND_DONE, later_ms());
            w.ok = ($urandom_range(0, 3) != 0);
            send_word(w);
         end else begin
            send_word(noise_word());
         end
      end
   endtask

   task automatic test_directed();
      req_type w;
      send_word(make_word(KIND_TICK, 32'd1000));
      send_word(make_word(KIND_DRAIN, 32'd1000));
      w = make_word(KIND_RECORD, 32'd2000);
      w.event_code  = '0;
      w.aux_byte    = '0;
      w.detail_word = '0;
      w.millivolts  = '0;
      w.percent     = '0;
      w.charging    = 1'b0;
      send_word(w);
      w = make_word(KIND_RECORD, 32'd2001);
      w.event_code  = '1;
      w.aux_byte    = '1;
      w.detail_word = '1;
      w.millivolts  = '1;
      w.percent     = '1;
      w.charging    = 1'b1;
      send_word(w);
      w = make_word(KIND_RECORD, 32'd2002);
      w.event_code = DROP_EVENT;
      send_word(w);
      w = make_word(KIND_RECORD, 32'd2003);
      w.event_code = 5'd18;
      w.percent    = 7'd100;
      send_word(w);
      send_word(make_word(KIND_TICK, 32'd2300));
      // inside poll interval
      send_word(make_word(KIND_TICK, 32'd2500));
      // oldest entry exactly at the age limit
      send_word(make_word(KIND_TICK, 32'd62000));
      w = make_word(KIND_DONE, 32'd62100);
      w.ok = 1'b0;
      send_word(w);
      send_word(make_word(KIND_TICK, 32'd62700));
      send_word(make_word(KIND_TICK, 32'd92100));
      send_word(make_word(KIND_DRAIN, 32'd92200));
      w = make_word(KIND_DONE, 32'd92300);
      w.ok = 1'b1;
      send_word(w);
      send_word(make_word(KIND_DRAIN, 32'd92400));
      send_word(make_word(KIND_TICK, 32'd93000));
      // millisecond counter wraps
      send_word(make_word(KIND_RECORD, 32'hFFFF_FF00));
      send_word(make_word(KIND_RECORD, 32'hFFFF_FFFF));
      send_word(make_word(KIND_TICK, 32'h0000_EA00));
      send_word(make_word(KIND_RECORD, 32'h0000_0100));
      send_word(make_word(KIND_DRAIN, 32'h0000_0200));
      w = make_word(KIND_DONE, 32'h0000_0300);
      w.ok = 1'b1;
      send_word(w);
      wait_drained();
   endtask

   task automatic test_config_extremes();
      cfg_type sets [5];
      req_type w;
      sets[0] = {6'd1, 32'd0, 32'd0, 32'd0};
      sets[1] = {6'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0};
      sets[2] = {6'd63, 32'd1000, 32'd500, 32'd100};
      sets[3] = {6'd32, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF};
      sets[4] = {RST_WATERMARK, RST_AGE_MS, RST_RETRY_MS, RST_POLL_MS};
      step_cap = 300;
      foreach (sets[k]) begin
         apply_settings(sets[k]);
         w    = make_word(KIND_DONE, later_ms());
         w.ok = 1'b1;
         send_word(w);
         send_word(make_word(KIND_TICK, later_ms()));
         run_mix(2);
         wait_drained();
      end
   endtask

   task automatic test_drop_saturation();
      req_type w;
      step_cap = 50;
      w    = make_word(KIND_DONE, later_ms());
      w.ok = 1'b1;
      send_word(w);
      repeat (RING_DEPTH + 256) send_word(make_word(KIND_RECORD, later_ms()));
      send_word(make_word(KIND_TICK, later_ms()));
      send_word(make_word(KIND_DRAIN, later_ms()));
      w    = make_word(KIND_DONE, later_ms());
      w.ok = 1'b0;
      send_word(w);
      send_word(make_word(KIND_RECORD, later_ms()));
      send_word(make_word(KIND_DRAIN, later_ms()));
      w    = make_word(KIND_DONE, later_ms());
      w.ok = 1'b1;
      send_word(w);
      wait_drained();
   endtask

   task automatic test_backpressure();
      req_type w;
      steady = 1'b1;
      w      = make_word(KIND_DONE, later_ms());
      w.ok   = 1'b1;
      send_word(w);
      hold_cycles = 150;
      repeat (4) send_word(make_word(KIND_RECORD, later_ms()));
      send_word(make_word(KIND_DRAIN, later_ms()));
      send_word(make_word(KIND_TICK, later_ms()));
      send_word(make_word(KIND_DRAIN, later_ms()));
      repeat (2) send_word(make_word(KIND_RECORD, later_ms()));
      send_word(make_word(KIND_DRAIN, later_ms()));
      wait_drained();
      steady = 1'b0;
   endtask

   task automatic test_random_traffic();
      cfg_type c;
      int      phase;
      for (phase = 0; phase < 2; phase++) begin
         c.fill_mark   = 6'($urandom_range(1, RING_DEPTH));
         c.age_limit   = $urandom_range(200, 5000);
         c.retry_hold  = $urandom_range(100, 3000);
         c.poll_period = $urandom_range(0, 300);
         apply_settings(c);
         step_cap = 400;
         steady   = (phase == 1);
         run_mix(4);
         wait_drained();
      end
      steady = 1'b0;
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("[%0t] %s: expected 0x%0h, got 0x%0h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_words.size() == 0) begin
            $display("[%0t] word with nothing expected: expected none, got 0x%0h",
                     $time, rsp_data);
            error_count++;
         end else begin
            want = awaited_words.pop_front();
            compare_field("is_row", 32'(want.is_row), 32'(rsp_data.is_row));
            compare_field("flush_due", 32'(want.flush_due), 32'(rsp_data.flush_due));
            compare_field("row_event", 32'(want.row_event), 32'(rsp_data.row_event));
            compare_field("row_aux", 32'(want.row_aux), 32'(rsp_data.row_aux));
            compare_field("row_detail", want.row_detail, rsp_data.row_detail);
            compare_field("row_ms", want.row_ms, rsp_data.row_ms);
            compare_field("row_millivolts", 32'(want.row_millivolts),
                          32'(rsp_data.row_millivolts));
            compare_field("row_percent", 32'(want.row_percent), 32'(rsp_data.row_percent));
            compare_field("row_charging", 32'(want.row_charging),
                          32'(rsp_data.row_charging));
            compare_field("last", 32'(want.last), 32'(rsp_data.last));
            if (want.is_row) rows_out++;
            else verdicts_out++;
            if (want.flush_due) due_out++;
         end
      end
   end

   initial begin : rsp_side
      int pause;
      forever begin
         if (hold_cycles > 0) begin
            rsp_stall = 1'b1;
            repeat (hold_cycles) @(negedge clock);
            hold_cycles = 0;
         end
         pause     = steady ? 0 : $urandom_range(0, 6);
         rsp_stall = (pause != 0);
         repeat (pause) @(negedge clock);
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid && hold_cycles == 0);
         @(negedge clock);
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("[%0t] no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("tb_event_log_ring_with_drop_count_core: errors");
      $finish;
   end

   initial begin : main
      repeat (6) @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_config_extremes();
      test_drop_saturation();
      test_backpressure();
      test_random_traffic();
      wait_drained();
      $display("run covered %0d words in, %0d log rows and %0d tick verdicts out (%0d due)",
               words_in, rows_out, verdicts_out, due_out);
      $display("drop count peaked at %0d over %0d register settings incl. extremes",
               peak_lost, settings_applied);
      if (error_count == 0) begin
         $display("tb_event_log_ring_with_drop_count_core: clean");
      end else begin
         $display("tb_event_log_ring_with_drop_count_core: errors");
      end
      $finish;
   end

endmodule
